// File: hw/rtl/ims_pkg.sv
package ims_pkg;

  // Widths of the configuration port and the phase wait counter
  localparam int CFG_W          = 16;
  localparam int CFG_ADDR_W     = 1;
  localparam int WAIT_W         = 16;
  localparam int BIT_IDX_W      = 4;
  localparam int BYTE_W         = 8;
  localparam int BITS_PER_BYTE  = 8;

  // Reset values of the timing registers
  localparam logic [CFG_W-1:0] BIT_WAIT_RESET  = CFG_W'(2);
  localparam logic [CFG_W-1:0] EDGE_WAIT_RESET = CFG_W'(5);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_WAIT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_WAIT = CFG_ADDR_W'(1);

  // Stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  // Command codes
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_START_A      = 4'd1,
    PH_START_B      = 4'd2,
    PH_STOP_A       = 4'd3,
    PH_STOP_B       = 4'd4,
    PH_WR_SETUP     = 4'd5,
    PH_WR_HIGH      = 4'd6,
    PH_WR_ACK_SETUP = 4'd7,
    PH_WR_ACK_HIGH  = 4'd8,
    PH_RD_HIGH      = 4'd9,
    PH_RD_LOW       = 4'd10,
    PH_RD_ACK_SETUP = 4'd11,
    PH_RD_ACK_HIGH  = 4'd12
  } phase_t;

  // One tick item
  typedef struct packed {
    logic              cmd_valid;
    func_t             func;
    logic [BYTE_W-1:0] write_data;
    logic              send_ack;
    logic              sda_in;
  } tick_t;

  // One result item
  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_received;
  } result_t;

  // Timing configuration
  typedef struct packed {
    logic [CFG_W-1:0] bit_wait;
    logic [CFG_W-1:0] edge_wait;
  } cfg_t;

  // Counter load for a phase of the given length: zero counts as one tick,
  // a length beyond the counter range saturates
  function automatic logic [WAIT_W-1:0] load_count(input logic [CFG_W-1:0] ticks);
    localparam int SUM_W = CFG_W + WAIT_W;
    logic [CFG_W-1:0] dec;
    logic [SUM_W-1:0] wide_dec;
    logic [SUM_W-1:0] wide_max;
    dec      = (ticks == '0) ? '0 : ticks - CFG_W'(1);
    wide_dec = SUM_W'(dec);
    wide_max = (SUM_W'(1) << WAIT_W) - SUM_W'(1);
    if (wide_dec > wide_max) begin
      return WAIT_W'(wide_max);
    end
    return WAIT_W'(wide_dec);
  endfunction

endpackage

// File: hw/rtl/ims_core.sv
module ims_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  ims_pkg::tick_t   tick,
  input  ims_pkg::cfg_t    cfg,
  output ims_pkg::result_t res
);

  ims_pkg::phase_t                  phase_r, phase_nxt;
  logic [ims_pkg::WAIT_W-1:0]       wait_r, wait_nxt;
  logic [ims_pkg::BIT_IDX_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [ims_pkg::BYTE_W-1:0]       shift_r, shift_nxt;
  logic [ims_pkg::BYTE_W-1:0]       rx_r, rx_nxt;
  logic                             scl_r, scl_nxt;
  logic                             sda_r, sda_nxt;
  logic                             ack_seen_r, ack_seen_nxt;
  logic                             ack_choice_r, ack_choice_nxt;
  logic                             done;
  logic                             expired;
  logic [ims_pkg::BIT_IDX_W-1:0]    bit_idx_inc;
  logic                             more_bits;
  logic [ims_pkg::WAIT_W-1:0]       bit_load;
  logic [ims_pkg::WAIT_W-1:0]       edge_load;

  assign expired     = (wait_r == '0);
  assign bit_idx_inc = bit_idx_r + ims_pkg::BIT_IDX_W'(1);
  assign more_bits   = (bit_idx_inc < ims_pkg::BIT_IDX_W'(ims_pkg::BITS_PER_BYTE));
  assign bit_load    = ims_pkg::load_count(cfg.bit_wait);
  assign edge_load   = ims_pkg::load_count(cfg.edge_wait);

  // Next phase, wait count and bit index
  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    bit_idx_nxt = bit_idx_r;
    done        = 1'b0;
    if (phase_r == ims_pkg::PH_IDLE) begin
      if (tick.cmd_valid) begin
        bit_idx_nxt = '0;
        case (tick.func)
          ims_pkg::FUNC_START: begin
            phase_nxt = ims_pkg::PH_START_A;
            wait_nxt  = edge_load;
          end
          ims_pkg::FUNC_STOP: begin
            phase_nxt = ims_pkg::PH_STOP_A;
            wait_nxt  = edge_load;
          end
          ims_pkg::FUNC_WRITE: begin
            phase_nxt = ims_pkg::PH_WR_SETUP;
            wait_nxt  = bit_load;
          end
          default: begin
            phase_nxt = ims_pkg::PH_RD_HIGH;
            wait_nxt  = bit_load;
          end
        endcase
      end
    end else if (!expired) begin
      wait_nxt = wait_r - ims_pkg::WAIT_W'(1);
    end else begin
      case (phase_r)
        ims_pkg::PH_START_A: begin
          phase_nxt = ims_pkg::PH_START_B;
          wait_nxt  = edge_load;
        end
        ims_pkg::PH_STOP_A: begin
          phase_nxt = ims_pkg::PH_STOP_B;
          wait_nxt  = edge_load;
        end
        ims_pkg::PH_WR_SETUP: begin
          phase_nxt = ims_pkg::PH_WR_HIGH;
          wait_nxt  = bit_load;
        end
        ims_pkg::PH_WR_HIGH: begin
          bit_idx_nxt = bit_idx_inc;
          phase_nxt   = more_bits ? ims_pkg::PH_WR_SETUP : ims_pkg::PH_WR_ACK_SETUP;
          wait_nxt    = bit_load;
        end
        ims_pkg::PH_WR_ACK_SETUP: begin
          phase_nxt = ims_pkg::PH_WR_ACK_HIGH;
          wait_nxt  = bit_load;
        end
        ims_pkg::PH_RD_HIGH: begin
          phase_nxt = ims_pkg::PH_RD_LOW;
          wait_nxt  = bit_load;
        end
        ims_pkg::PH_RD_LOW: begin
          bit_idx_nxt = bit_idx_inc;
          phase_nxt   = more_bits ? ims_pkg::PH_RD_HIGH : ims_pkg::PH_RD_ACK_SETUP;
          wait_nxt    = bit_load;
        end
        ims_pkg::PH_RD_ACK_SETUP: begin
          phase_nxt = ims_pkg::PH_RD_ACK_HIGH;
          wait_nxt  = bit_load;
        end
        ims_pkg::PH_START_B, ims_pkg::PH_STOP_B,
        ims_pkg::PH_WR_ACK_HIGH, ims_pkg::PH_RD_ACK_HIGH: begin
          phase_nxt = ims_pkg::PH_IDLE;
          wait_nxt  = '0;
          done      = 1'b1;
        end
        default: begin
          phase_nxt = ims_pkg::PH_IDLE;
          wait_nxt  = '0;
        end
      endcase
    end
  end

  // Pin levels, shift byte and captured bits
  always_comb begin
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    shift_nxt      = shift_r;
    rx_nxt         = rx_r;
    ack_seen_nxt   = ack_seen_r;
    ack_choice_nxt = ack_choice_r;
    if (phase_r == ims_pkg::PH_IDLE) begin
      if (tick.cmd_valid) begin
        case (tick.func)
          ims_pkg::FUNC_START: begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
          ims_pkg::FUNC_STOP: begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end
          ims_pkg::FUNC_WRITE: begin
            shift_nxt = tick.write_data;
            sda_nxt   = tick.write_data[ims_pkg::BYTE_W-1];
          end
          default: begin
            ack_choice_nxt = tick.send_ack;
            shift_nxt      = '0;
            sda_nxt        = 1'b1;
            scl_nxt        = 1'b1;
          end
        endcase
      end
    end else if (expired) begin
      case (phase_r)
        ims_pkg::PH_START_A: sda_nxt = 1'b0;
        ims_pkg::PH_START_B: scl_nxt = 1'b0;
        ims_pkg::PH_STOP_A:  sda_nxt = 1'b1;
        ims_pkg::PH_WR_SETUP, ims_pkg::PH_WR_ACK_SETUP,
        ims_pkg::PH_RD_ACK_SETUP: scl_nxt = 1'b1;
        ims_pkg::PH_WR_HIGH: begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_r[ims_pkg::BYTE_W-2:0], 1'b0};
          sda_nxt   = more_bits ? shift_r[ims_pkg::BYTE_W-2] : 1'b1;
        end
        ims_pkg::PH_WR_ACK_HIGH: begin
          ack_seen_nxt = tick.sda_in;
          scl_nxt      = 1'b0;
        end
        ims_pkg::PH_RD_HIGH: begin
          shift_nxt = {shift_r[ims_pkg::BYTE_W-2:0], tick.sda_in};
          scl_nxt   = 1'b0;
        end
        ims_pkg::PH_RD_LOW: begin
          if (more_bits) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = ~ack_choice_r;
          end
        end
        ims_pkg::PH_RD_ACK_HIGH: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
          rx_nxt  = shift_r;
        end
        default: begin
          scl_nxt = scl_r;
        end
      endcase
    end
  end

  // Advance the sequencer by one tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ims_pkg::PH_IDLE;
      wait_r       <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      rx_r         <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_seen_r   <= 1'b1;
      ack_choice_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      rx_r         <= rx_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_seen_r   <= ack_seen_nxt;
      ack_choice_r <= ack_choice_nxt;
    end
  end

  // Result of this tick
  assign res.scl_out      = scl_nxt;
  assign res.sda_out      = sda_nxt;
  assign res.busy_res     = (phase_nxt != ims_pkg::PH_IDLE);
  assign res.done_res     = done;
  assign res.read_data    = rx_nxt;
  assign res.ack_received = ack_seen_nxt;

endmodule

// File: hw/rtl/i2c_master_byte_sequencer.sv
// Path: a tick transaction is held in the input register at acceptance, and its result
// is then loaded into the result register, whose valid flag drives out_tvalid.
// Throughput: one tick per cycle while the result side keeps taking results; a
// stalled result lets one more tick into the input register, then blocks input.
// Reset: synchronous active-low rst_n; bus released, sequencer idle,
// bit wait 2 and edge wait 5 ticks.
module i2c_master_byte_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] write_data, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [ims_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] cmd_valid, [2:1] func
  input  logic [ims_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
  // [12] ack_received, [15:13] zero
  output logic [ims_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [ims_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ims_pkg::CFG_W-1:0]          cfg_wdata
);

  logic              in_valid_r;
  ims_pkg::tick_t    in_tick_r;
  logic              out_valid_r;
  ims_pkg::result_t  out_res_r;
  ims_pkg::cfg_t     cfg_r;
  ims_pkg::result_t  res;
  logic              advance;
  logic              step_en;

  // Result register free or draining this cycle
  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_wait  <= ims_pkg::BIT_WAIT_RESET;
      cfg_r.edge_wait <= ims_pkg::EDGE_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ims_pkg::REG_BIT_WAIT:  cfg_r.bit_wait  <= cfg_wdata;
        ims_pkg::REG_EDGE_WAIT: cfg_r.edge_wait <= cfg_wdata;
        default:                cfg_r.bit_wait  <= cfg_r.bit_wait;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_tick_r.cmd_valid  <= in_tuser[0];
      in_tick_r.func       <= ims_pkg::func_t'(in_tuser[2:1]);
      in_tick_r.write_data <= in_tdata[7:0];
      in_tick_r.send_ack   <= in_tdata[8];
      in_tick_r.sda_in     <= in_tdata[9];
    end
  end

  ims_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .tick    (in_tick_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.ack_received, out_res_r.read_data,
                       out_res_r.done_res, out_res_r.busy_res,
                       out_res_r.sda_out, out_res_r.scl_out};

endmodule

// File: hw/rtl/ims_checker.sv
module ims_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ims_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A completing tick never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done and busy together");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A draining output never blocks the input side
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind i2c_master_byte_sequencer ims_checker u_ims_checker (.*);
